// File: design/ax25_pkg.sv
package ax25_pkg;

  typedef enum logic [1:0] {
    PH_DEST = 2'd0,
    PH_SRC  = 2'd1,
    PH_DIGI = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_PID = 2'd1,
    ST_BAD_CALL = 2'd2,
    ST_UNDEC   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_OWN_CHARS = 2'd0,
    REG_OWN_SSID  = 2'd1,
    REG_KENWOOD   = 2'd2,
    REG_OPENTRAC  = 2'd3
  } reg_e;

  localparam logic [7:0] SPACE_MASK = 8'hfe;
  localparam logic [7:0] SPACE_CODE = 8'h40;
  localparam logic [7:0] SSID_FLAG_BITS = 8'he1;
  localparam logic [7:0] PID_TEXT   = 8'hf0;
  localparam logic [7:0] PID_CC     = 8'hcc;
  localparam logic [7:0] PID_CD     = 8'hcd;
  localparam logic [7:0] PID_CF     = 8'hcf;
  localparam logic [7:0] PID_OTRAC  = 8'h77;
  localparam logic [7:0] UI_MASK    = 8'hef;
  localparam logic [7:0] UI_CODE    = 8'h03;
  localparam logic [3:0] MIN_BYTES  = 4'd15;

  function automatic logic char_ok(input logic [6:0] c);
    return ((c >= 7'h41) && (c <= 7'h5a)) || ((c >= 7'h30) && (c <= 7'h39));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// File: design/ax25_header_parser_core.sv
// AX.25 header parser.
// s_axis carries one frame byte per word (tdata = frame_byte), with tlast on
// the final byte of a frame. m_axis carries one result word per frame, sent
// for the word that had tlast set; other bytes give no result.
// cfg_* writes the four settings registers (index 0 own callsign, 1 own SSID,
// 2 Kenwood mode, 3 Opentrac enable); write only while no frame is open.
// Throughput: one byte per cycle unless the receiver stalls. Each byte updates
// the frame state in the cycle it is accepted; the final byte's record is formed
// from that state in the same cycle and lands in the output register, visible
// in the cycle after acceptance.
// When the receiver stalls, the output register holds its record and
// s_axis_tready stays low until that record is taken, so every byte waits;
// with m_axis_tready high the register is emptied and refilled in the same
// cycle and bytes keep flowing.
// Reset (rst_ni low, asynchronous) clears the frame state, the output valid
// flag and the settings registers.
module ax25_header_parser_core #(
  parameter int MAX_DIGIS   = 8,
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [2] is_remote, [6:3] digi_count, [14:7] primitive_res,
  // [15] pid_present, [23:16] pid, [32:24] payload_size, [40:33] destination
  // flags, [48:41] source_flags, [55:49] zero
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int DW = $clog2(MAX_DIGIS + 1);
  localparam int PW = $clog2(MAX_PAYLOAD + 1);

  logic [47:0] own_chars_q;
  logic [3:0]  own_ssid_q;
  logic        kenwood_q, otrac_q;

  logic [7:0]  buf_q [6];
  logic [2:0]  fill_q, fill_d;
  ax25_pkg::phase_e phase_q, phase_d;
  logic [3:0]  seen_q, seen_d;
  logic        calls_ok_q, calls_ok_d;
  logic [7:0]  fd_chars_q [6];
  logic [7:0]  fd_chars_d [6];
  logic [2:0]  fd_len_q, fd_len_d;
  logic [3:0]  fd_ssid_q, fd_ssid_d;
  logic        fd_h_q, fd_h_d;
  logic [7:0]  dflags_q, dflags_d, sflags_q, sflags_d;
  logic        dssid_nz_q, dssid_nz_d, flex_q, flex_d;
  logic [DW-1:0] dcnt_q, dcnt_d;
  logic        prim_p_q, prim_p_d, pid_p_q, pid_p_d;
  logic [7:0]  prim_q, prim_d, pid_q, pid_d;
  logic [PW-1:0] pay_q, pay_d;

  logic        out_valid_q;
  logic [55:0] out_q;
  logic        accept, out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_chars_q <= '0;
      own_ssid_q  <= '0;
      kenwood_q   <= 1'b0;
      otrac_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ax25_pkg::REG_OWN_CHARS: own_chars_q <= cfg_data_i;
        ax25_pkg::REG_OWN_SSID:  own_ssid_q  <= cfg_data_i[3:0];
        ax25_pkg::REG_KENWOOD:   kenwood_q   <= cfg_data_i[0];
        ax25_pkg::REG_OPENTRAC:  otrac_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Working view of the block with the incoming byte in place.
  logic [7:0] blk [7];
  logic       blk_full;
  logic       ok_blk;
  logic [2:0] blk_len;
  logic [7:0] blk_chars [6];
  logic [7:0] sb;
  logic [3:0] sb_ssid;
  logic [7:0] tail_b [7];
  logic [2:0] ntail;
  logic [6:0] ch;
  logic       own_match, remote, pid_good, undec;
  logic [5:0] own_nz;
  logic [2:0] own_len;
  logic [4:0] hop_total;
  ax25_pkg::status_e status;

  always_comb begin
    for (int i = 0; i < 6; i++) blk[i] = buf_q[i];
    blk[6] = s_axis_tdata;
    if (fill_q < 3'd6) blk[fill_q] = s_axis_tdata;
    blk_full = (phase_q != ax25_pkg::PH_TAIL) && (fill_q == 3'd6);
    sb      = blk[6];
    sb_ssid = sb[4:1];

    // Callsign compaction over six independent positions.
    blk_len = '0;
    ok_blk  = 1'b1;
    ch      = '0;
    for (int i = 0; i < 6; i++) blk_chars[i] = '0;
    for (int i = 0; i < 6; i++) begin
      if ((blk[i] & ax25_pkg::SPACE_MASK) != ax25_pkg::SPACE_CODE) begin
        ch = blk[i][7:1];
        if (!ax25_pkg::char_ok(ch)) ok_blk = 1'b0;
        blk_chars[blk_len] = {1'b0, ch};
        blk_len = blk_len + 3'd1;
      end
    end
    if (blk_len == 3'd0) ok_blk = 1'b0;

    fill_d = fill_q; phase_d = phase_q; calls_ok_d = calls_ok_q;
    fd_chars_d = fd_chars_q; fd_len_d = fd_len_q; fd_ssid_d = fd_ssid_q;
    fd_h_d = fd_h_q; dflags_d = dflags_q; sflags_d = sflags_q;
    dssid_nz_d = dssid_nz_q; flex_d = flex_q; dcnt_d = dcnt_q;
    prim_p_d = prim_p_q; prim_d = prim_q; pid_p_d = pid_p_q; pid_d = pid_q;
    pay_d = pay_q;
    seen_d = (seen_q < ax25_pkg::MIN_BYTES) ? seen_q + 4'd1 : seen_q;

    // Tail bytes: the incoming one, or at frame end the partial digi block.
    ntail = 3'd0;
    for (int i = 0; i < 7; i++) tail_b[i] = blk[i];
    if (phase_q == ax25_pkg::PH_TAIL) begin
      ntail = 3'd1;
      tail_b[0] = s_axis_tdata;
    end else if (blk_full) begin
      fill_d = 3'd0;
      case (phase_q)
        ax25_pkg::PH_DEST: begin
          flex_d     = blk[1][0];
          dflags_d   = sb & ax25_pkg::SSID_FLAG_BITS;
          dssid_nz_d = sb_ssid != 4'd0;
          if (!ok_blk) calls_ok_d = 1'b0;
          phase_d = ax25_pkg::PH_SRC;
        end
        ax25_pkg::PH_SRC: begin
          sflags_d = sb & ax25_pkg::SSID_FLAG_BITS;
          if (!ok_blk) calls_ok_d = 1'b0;
          phase_d = sb[0] ? ax25_pkg::PH_TAIL : ax25_pkg::PH_DIGI;
        end
        default: begin
          if (dcnt_q < DW'(MAX_DIGIS)) begin
            if (dcnt_q == '0) begin
              fd_chars_d = blk_chars;
              fd_len_d   = blk_len;
              fd_ssid_d  = sb_ssid;
              fd_h_d     = sb[7];
            end
            if (!ok_blk) calls_ok_d = 1'b0;
            dcnt_d = dcnt_q + DW'(1);
          end
          if (sb[0]) phase_d = ax25_pkg::PH_TAIL;
        end
      endcase
    end else begin
      fill_d = fill_q + 3'd1;
      if (s_axis_tlast && phase_q == ax25_pkg::PH_DIGI) ntail = fill_q + 3'd1;
    end

    // Up to six tail bytes in sequence: two header slots then a count.
    for (int i = 0; i < 7; i++) begin
      if (3'(i) < ntail) begin
        if (!prim_p_d) begin
          prim_p_d = 1'b1; prim_d = tail_b[i];
        end else if (!pid_p_d) begin
          pid_p_d = 1'b1; pid_d = tail_b[i];
        end else if (pay_d < PW'(MAX_PAYLOAD)) begin
          pay_d = pay_d + PW'(1);
        end
      end
    end

    // Remote judgment from the first digipeater.
    for (int k = 0; k < 6; k++) own_nz[k] = own_chars_q[40-8*k +: 8] != 8'd0;
    own_len = 3'd6;
    for (int k = 5; k >= 0; k--) if (!own_nz[k]) own_len = 3'(k);
    own_match = (own_len == fd_len_d) && (fd_ssid_d == own_ssid_q);
    for (int k = 0; k < 6; k++)
      if (3'(k) < own_len && own_chars_q[40-8*k +: 8] != fd_chars_d[k])
        own_match = 1'b0;
    hop_total = (fd_ssid_d != 4'd0) ? 5'd15 : 5'd0;
    if (fd_len_d != 3'd0 && ax25_pkg::is_digit(fd_chars_d[fd_len_d - 3'd1])) begin
      hop_total = {1'b0, fd_chars_d[fd_len_d - 3'd1][3:0]};
      if (fd_len_d >= 3'd2 && hop_total < 5'd6 &&
          fd_chars_d[fd_len_d - 3'd2] == 8'h31)
        hop_total = hop_total + 5'd10;
    end
    if (dcnt_d == '0) remote = 1'b0;
    else if (fd_h_d || dssid_nz_d) remote = 1'b1;
    else if (own_match) remote = 1'b0;
    else remote = hop_total > {1'b0, fd_ssid_d};

    if (!kenwood_q)
      pid_good = pid_d == ax25_pkg::PID_TEXT || pid_d == ax25_pkg::PID_CC ||
                 pid_d == ax25_pkg::PID_CD || pid_d == ax25_pkg::PID_CF ||
                 (otrac_q && pid_d == ax25_pkg::PID_OTRAC);
    else
      pid_good = ((prim_d & ax25_pkg::UI_MASK) == ax25_pkg::UI_CODE) &&
                 (pid_d == ax25_pkg::PID_TEXT ||
                  (otrac_q && pid_d == ax25_pkg::PID_OTRAC));

    undec = (seen_d < ax25_pkg::MIN_BYTES) || flex_d || !prim_p_d;
    if (undec) status = ax25_pkg::ST_UNDEC;
    else if (!calls_ok_d) status = ax25_pkg::ST_BAD_CALL;
    else if (!pid_p_d) status = kenwood_q ? ax25_pkg::ST_BAD_PID : ax25_pkg::ST_OK;
    else status = pid_good ? ax25_pkg::ST_OK : ax25_pkg::ST_BAD_PID;
  end

  logic [55:0] rec;
  logic        ok_full;
  always_comb begin
    ok_full = (status == ax25_pkg::ST_OK) || (status == ax25_pkg::ST_BAD_PID);
    rec = '0;
    rec[1:0] = status;
    if (status != ax25_pkg::ST_UNDEC) begin
      rec[2]     = ok_full && remote;
      rec[6:3]   = 4'(dcnt_d);
      rec[14:7]  = prim_d;
      rec[40:33] = dflags_d;
      rec[48:41] = sflags_d;
      if (ok_full && pid_p_d) begin
        rec[15]    = 1'b1;
        rec[23:16] = pid_d;
        rec[32:24] = 9'(pay_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && phase_q != ax25_pkg::PH_TAIL && fill_q < 3'd6)
      buf_q[fill_q] <= s_axis_tdata;
    if (accept && s_axis_tlast) out_q <= rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fill_q <= '0; phase_q <= ax25_pkg::PH_DEST; seen_q <= '0;
      calls_ok_q <= 1'b1;
      for (int i = 0; i < 6; i++) fd_chars_q[i] <= '0;
      fd_len_q <= '0; fd_ssid_q <= '0; fd_h_q <= 1'b0;
      dflags_q <= '0; sflags_q <= '0; dssid_nz_q <= 1'b0; flex_q <= 1'b0;
      dcnt_q <= '0; prim_p_q <= 1'b0; prim_q <= '0; pid_p_q <= 1'b0;
      pid_q <= '0; pay_q <= '0;
    end else begin
      if (accept && s_axis_tlast) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (accept) begin
        if (s_axis_tlast) begin
          fill_q <= '0; phase_q <= ax25_pkg::PH_DEST; seen_q <= '0;
          calls_ok_q <= 1'b1;
          for (int i = 0; i < 6; i++) fd_chars_q[i] <= '0;
          fd_len_q <= '0; fd_ssid_q <= '0; fd_h_q <= 1'b0;
          dflags_q <= '0; sflags_q <= '0; dssid_nz_q <= 1'b0; flex_q <= 1'b0;
          dcnt_q <= '0; prim_p_q <= 1'b0; prim_q <= '0; pid_p_q <= 1'b0;
          pid_q <= '0; pay_q <= '0;
        end else begin
          fill_q <= fill_d; phase_q <= phase_d; seen_q <= seen_d;
          calls_ok_q <= calls_ok_d; fd_chars_q <= fd_chars_d;
          fd_len_q <= fd_len_d; fd_ssid_q <= fd_ssid_d; fd_h_q <= fd_h_d;
          dflags_q <= dflags_d; sflags_q <= sflags_d;
          dssid_nz_q <= dssid_nz_d; flex_q <= flex_d; dcnt_q <= dcnt_d;
          prim_p_q <= prim_p_d; prim_q <= prim_d; pid_p_q <= pid_p_d;
          pid_q <= pid_d; pay_q <= pay_d;
        end
      end
    end
  end

endmodule

// File: sim/ax25_header_parser_core_test.sv
module ax25_header_parser_core_test;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 270;
  localparam int MAX_DIGI_CNT = 8;
  localparam int MAX_PAY      = 256;

  typedef struct packed {
    ax25_pkg::status_e status;
    logic       remote;
    logic [3:0] digis;
    logic [7:0] prim;
    logic       pid_present;
    logic [7:0] pid;
    logic [8:0] pay_size;
    logic [7:0] dst_flag_bits;
    logic [7:0] src_flags;
  } header_rec_t;

  class parser_scoreboard;
    // settings registers
    bit [47:0] own_chars;
    bit [3:0]  own_ssid;
    bit        kenwood;
    bit        opentrac;
    // per-frame state
    bit [7:0]  blk[7];
    int        fill;
    ax25_pkg::phase_e ph;
    int        seen;
    bit        calls_ok;
    bit [7:0]  d_chars[6];
    int        d_len;
    bit [3:0]  d_ssid;
    bit        d_hbit;
    bit [7:0]  dflags;
    bit [7:0]  sflags;
    bit        dssid_nz;
    bit        flexnet;
    int        ndigi;
    bit        prim_p;
    bit [7:0]  prim;
    bit        pid_p;
    bit [7:0]  pidv;
    int        pay;

    header_rec_t expected_recs[$];
    int errors;
    int checked;
    int status_cnt[4];

    function new();
      own_chars = '0;
      own_ssid = '0;
      kenwood = 0;
      opentrac = 0;
      errors = 0;
      checked = 0;
      foreach (status_cnt[i]) status_cnt[i] = 0;
      clear_frame();
    endfunction

    function void set_reg(ax25_pkg::reg_e idx, bit [47:0] val);
      case (idx)
        ax25_pkg::REG_OWN_CHARS: own_chars = val;
        ax25_pkg::REG_OWN_SSID:  own_ssid = val[3:0];
        ax25_pkg::REG_KENWOOD:   kenwood = val[0];
        ax25_pkg::REG_OPENTRAC:  opentrac = val[0];
        default: ;
      endcase
    endfunction

    function void clear_frame();
      foreach (blk[i]) blk[i] = '0;
      foreach (d_chars[i]) d_chars[i] = '0;
      fill = 0;
      ph = ax25_pkg::PH_DEST;
      seen = 0;
      calls_ok = 1;
      d_len = 0;
      d_ssid = '0;
      d_hbit = 0;
      dflags = '0;
      sflags = '0;
      dssid_nz = 0;
      flexnet = 0;
      ndigi = 0;
      prim_p = 0;
      prim = '0;
      pid_p = 0;
      pidv = '0;
      pay = 0;
    endfunction

    function int pending();
      return expected_recs.size();
    endfunction

    function bit legal_char(bit [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function void take_block();
      bit [7:0] ch[6];
      int n;
      bit ok;
      bit [7:0] sb;
      bit [3:0] ssid;
      bit fin;
      n = 0;
      ok = 1;
      foreach (ch[i]) ch[i] = '0;
      for (int i = 0; i < 6; i++) begin
        if ((blk[i] & ax25_pkg::SPACE_MASK) != ax25_pkg::SPACE_CODE) begin
          ch[n] = blk[i] >> 1;
          if (!legal_char(ch[n])) ok = 0;
          n++;
        end
      end
      ok = ok && (n >= 1);
      sb = blk[6];
      ssid = sb[4:1];
      fin = sb[0];
      if (ph == ax25_pkg::PH_DEST) begin
        flexnet = blk[1][0];
        dflags = sb & ax25_pkg::SSID_FLAG_BITS;
        dssid_nz = (ssid != 0);
        if (!ok) calls_ok = 0;
        ph = ax25_pkg::PH_SRC;
      end else if (ph == ax25_pkg::PH_SRC) begin
        sflags = sb & ax25_pkg::SSID_FLAG_BITS;
        if (!ok) calls_ok = 0;
        ph = fin ? ax25_pkg::PH_TAIL : ax25_pkg::PH_DIGI;
      end else begin
        if (ndigi < MAX_DIGI_CNT) begin
          if (ndigi == 0) begin
            d_chars = ch;
            d_len = n;
            d_ssid = ssid;
            d_hbit = sb[7];
          end
          if (!ok) calls_ok = 0;
          ndigi++;
        end
        if (fin) ph = ax25_pkg::PH_TAIL;
      end
    endfunction

    function void take_tail(bit [7:0] b);
      if (!prim_p) begin
        prim_p = 1;
        prim = b;
      end else if (!pid_p) begin
        pid_p = 1;
        pidv = b;
      end else if (pay < MAX_PAY) begin
        pay++;
      end
    endfunction

    function bit own_match();
      int olen;
      bit [7:0] c;
      olen = 0;
      for (int k = 0; k < 6; k++) begin
        c = own_chars[40 - 8 * k +: 8];
        if (c == 0) break;
        olen++;
      end
      if (olen != d_len) return 0;
      for (int k = 0; k < olen; k++)
        if (own_chars[40 - 8 * k +: 8] != d_chars[k]) return 0;
      return d_ssid == own_ssid;
    endfunction

    function bit via_digi();
      int total;
      bit [7:0] c;
      if (ndigi == 0) return 0;
      if (d_hbit || dssid_nz) return 1;
      if (own_match()) return 0;
      total = (d_ssid != 0) ? 15 : 0;
      if (d_len >= 1 && d_len <= 6) begin
        c = d_chars[d_len - 1];
        if (c >= 8'h30 && c <= 8'h39) begin
          total = c - 8'h30;
          // Hop totals 10..15 are spelled with a leading one, as in a "1n" suffix.
          if (d_len >= 2 && total < 6 && d_chars[d_len - 2] == 8'h31) total += 10;
        end
      end
      return total > d_ssid;
    endfunction

    function bit pid_accepted();
      bit otrac;
      otrac = opentrac && (pidv == ax25_pkg::PID_OTRAC);
      if (!kenwood)
        return pidv == ax25_pkg::PID_TEXT || pidv == ax25_pkg::PID_CC ||
               pidv == ax25_pkg::PID_CD || pidv == ax25_pkg::PID_CF || otrac;
      if ((prim & ax25_pkg::UI_MASK) != ax25_pkg::UI_CODE) return 0;
      return pidv == ax25_pkg::PID_TEXT || otrac;
    endfunction

    function void note_byte(bit [7:0] b, bit last_b);
      header_rec_t r;
      if (seen < 15) seen++;
      if (ph == ax25_pkg::PH_TAIL) begin
        take_tail(b);
      end else begin
        blk[fill] = b;
        fill++;
        if (fill >= 7) begin
          fill = 0;
          take_block();
        end
      end
      if (!last_b) return;
      // A frame ending inside an open digipeater block hands those bytes to the tail.
      if (ph == ax25_pkg::PH_DIGI)
        for (int i = 0; i < fill; i++) take_tail(blk[i]);
      r = '0;
      if (seen < 15 || flexnet || !prim_p) begin
        r.status = ax25_pkg::ST_UNDEC;
      end else begin
        if (!calls_ok) begin
          r.status = ax25_pkg::ST_BAD_CALL;
        end else begin
          r.remote = via_digi();
          if (!pid_p) r.status = kenwood ? ax25_pkg::ST_BAD_PID : ax25_pkg::ST_OK;
          else r.status = pid_accepted() ? ax25_pkg::ST_OK : ax25_pkg::ST_BAD_PID;
        end
        r.digis = ndigi[3:0];
        r.prim = prim;
        if (r.status != ax25_pkg::ST_BAD_CALL && pid_p) begin
          r.pid_present = 1;
          r.pid = pidv;
          r.pay_size = pay[8:0];
        end
        r.dst_flag_bits = dflags;
        r.src_flags = sflags;
      end
      expected_recs.push_back(r);
      clear_frame();
    endfunction

    function void cmp(string name, logic [8:0] exp_v, logic [8:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [55:0] d);
      header_rec_t e;
      if (expected_recs.size() == 0) begin
        $error("result word 0x%h arrived with no frame pending", d);
        errors++;
        return;
      end
      e = expected_recs.pop_front();
      checked++;
      status_cnt[e.status]++;
      cmp("status", 9'(e.status), 9'(d[1:0]));
      cmp("is_remote", 9'(e.remote), 9'(d[2]));
      cmp("digi_count", 9'(e.digis), 9'(d[6:3]));
      cmp("primitive_res", 9'(e.prim), 9'(d[14:7]));
      cmp("pid_present", 9'(e.pid_present), 9'(d[15]));
      cmp("pid", 9'(e.pid), 9'(d[23:16]));
      cmp("payload_size", e.pay_size, d[32:24]);
      cmp("destination_flags", 9'(e.dst_flag_bits), 9'(d[40:33]));
      cmp("source_flags", 9'(e.src_flags), 9'(d[48:41]));
      cmp("padding", 9'(0), 9'(d[55:49]));
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  ax25_header_parser_core DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  parser_scoreboard sb = new();
  bit [7:0]  frame_q[$];
  bit [7:0]  own_cs[6];
  int        own_len = 0;
  bit        burst = 0;
  int        bytes_sent = 0;
  int        frames_sent = 0;
  int        idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold so the output register backs up.
  initial begin
    int stall;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 6);
      if (!held && sb.checked == 20) begin
        stall = HOLD_CYCLES;
        held = 1;
      end
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata);
    end
  end

  task automatic cfg_write(ax25_pkg::reg_e idx, bit [47:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  task automatic send_byte(bit [7:0] b, bit last_b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    s_axis_tlast <= last_b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, last_b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    burst = ($urandom_range(0, 4) == 0);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  function automatic bit [7:0] rand_char();
    int r;
    r = $urandom_range(0, 35);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h30 + r - 26);
  endfunction

  function automatic void gen_call(output bit [7:0] cs[6], output int len);
    int kind;
    foreach (cs[i]) cs[i] = '0;
    kind = $urandom_range(0, 11);
    len = $urandom_range(1, 6);
    for (int i = 0; i < 6; i++) cs[i] = rand_char();
    if (kind == 5 || kind == 6) begin
      cs = own_cs;
      len = own_len;
    end else if (kind == 7 || kind == 8) begin
      // Hop-count style names such as a letter run ending in "n" or "1n".
      len = $urandom_range(2, 6);
      cs[len - 1] = 8'(8'h30 + $urandom_range(0, 9));
      if ($urandom_range(0, 1)) cs[len - 2] = 8'h31;
    end else if (kind == 9) begin
      cs[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 127));
    end else if (kind == 10 && $urandom_range(0, 3) == 0) begin
      len = 0;
    end
  endfunction

  function automatic void push_block(bit [7:0] cs[6], int len, bit [7:0] ssid_b,
                                     bit allow_low);
    bit [7:0] b;
    for (int i = 0; i < 6; i++) begin
      b = (i < len) ? {cs[i][6:0], 1'b0} : 8'h40;
      if (allow_low && $urandom_range(0, 9) == 0) b[0] = 1;
      frame_q.push_back(b);
    end
    frame_q.push_back(ssid_b);
  endfunction

  function automatic bit [7:0] ssid_byte(bit fin, bit zero_ssid);
    bit [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (zero_ssid) b[4:1] = '0;
    b[0] = fin;
    return b;
  endfunction

  function automatic bit [7:0] pick_pid();
    case ($urandom_range(0, 6))
      0, 1: return ax25_pkg::PID_TEXT;
      2: return ax25_pkg::PID_CC;
      3: return ax25_pkg::PID_CD;
      4: return ax25_pkg::PID_CF;
      5: return ax25_pkg::PID_OTRAC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_frame();
    bit [7:0] cs[6];
    int len;
    int kind;
    int ndig;
    int plen;
    frame_q.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      plen = $urandom_range(1, 40);
      repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
    gen_call(cs, len);
    push_block(cs, len, ssid_byte($urandom_range(0, 9) == 0, $urandom_range(0, 2) != 0),
               $urandom_range(0, 5) == 0);
    gen_call(cs, len);
    push_block(cs, len, ssid_byte(ndig == 0, 0), 1);
    for (int d = 0; d < ndig; d++) begin
      gen_call(cs, len);
      push_block(cs, len, ssid_byte(d == ndig - 1 && kind != 1, 0), 1);
    end
    if (kind == 1) begin
      // Frame stops inside an unterminated digipeater block.
      if (ndig == 0) frame_q[13][0] = 0;
      repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == 2) return;
    frame_q.push_back($urandom_range(0, 1)
                      ? (ax25_pkg::UI_CODE | 8'($urandom_range(0, 1) << 4))
                      : 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) != 0) begin
      frame_q.push_back(pick_pid());
      plen = ($urandom_range(0, 60) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
      repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    if (kind == 3) begin
      plen = $urandom_range(1, 16);
      while (frame_q.size() > plen) void'(frame_q.pop_back());
    end
  endfunction

  task automatic run_random(int nbytes);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      build_frame();
      send_frame();
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_own(bit [47:0] val);
    own_len = 0;
    foreach (own_cs[i]) own_cs[i] = val[40 - 8 * i +: 8];
    for (int i = 0; i < 6; i++) begin
      if (own_cs[i] == 0) break;
      own_len++;
    end
    cfg_write(ax25_pkg::REG_OWN_CHARS, val);
  endtask

  task automatic set_regs(bit [47:0] own, bit [3:0] ssid, bit kw, bit ot);
    set_own(own);
    cfg_write(ax25_pkg::REG_OWN_SSID, 48'(ssid));
    cfg_write(ax25_pkg::REG_KENWOOD, 48'(kw));
    cfg_write(ax25_pkg::REG_OPENTRAC, 48'(ot));
    cfg_valid_i <= 0;
  endtask

  function automatic bit [47:0] rand_own();
    bit [47:0] v;
    int len;
    v = '0;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) v[40 - 8 * i +: 8] = rand_char();
    return v;
  endfunction

  initial begin
    bit [7:0] cs[6];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed frames under reset settings.
    frame_q = '{8'h96};
    send_frame();
    frame_q.delete();
    repeat (15) frame_q.push_back(8'hff);
    send_frame();
    frame_q.delete();
    repeat (15) frame_q.push_back(8'h00);
    send_frame();
    // Flexnet marker in the destination block.
    frame_q = '{8'h82, 8'h85, 8'h86, 8'h88, 8'h8a, 8'h8c, 8'h60,
                8'h9c, 8'h60, 8'h40, 8'h40, 8'h40, 8'h40, 8'h61, 8'h03, 8'hf0};
    send_frame();
    // Address field only, then an all-space digipeater with the H bit set.
    frame_q = '{8'h82, 8'h84, 8'h40, 8'h40, 8'h40, 8'h40, 8'h60,
                8'h9c, 8'h60, 8'h40, 8'h40, 8'h40, 8'h40, 8'h61};
    send_frame();
    foreach (cs[i]) cs[i] = 8'h41;
    frame_q.delete();
    push_block(cs, 6, 8'h00, 0);
    push_block(cs, 6, 8'h00, 0);
    push_block(cs, 0, 8'he1, 0);
    frame_q.push_back(8'h03);
    frame_q.push_back(8'hf0);
    send_frame();
    drain();

    run_random(PHASE_BYTES);
    drain();
    set_regs(rand_own(), 4'($urandom_range(0, 15)), 0, 0);
    run_random(PHASE_BYTES);
    drain();
    set_regs(rand_own(), 4'($urandom_range(1, 15)), 1, 0);
    run_random(PHASE_BYTES);
    drain();
    set_regs(48'hffff_ffff_ffff, 4'hf, 1, 1);
    run_random(PHASE_BYTES);
    drain();
    set_regs(48'h0, 4'h0, 0, 1);
    run_random(PHASE_BYTES);
    drain();

    $display("Covered %0d bytes in %0d frames over five register settings; %0d records checked.",
             bytes_sent, frames_sent, sb.checked);
    $display("Status mix: %0d ok, %0d bad PID, %0d bad call, %0d undecodable.",
             sb.status_cnt[0], sb.status_cnt[1], sb.status_cnt[2], sb.status_cnt[3]);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
